>>> rtl/htsd_pkg.sv
// shared types and constants of the huffman tree stream decoder
`default_nettype none

package htsd_pkg;

    localparam int IDX_W     = 9;
    localparam int SYM_W     = 8;
    localparam int CNT_W     = 4;
    localparam int TABLE_MAX = 512;

    localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;

    // tuser codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_STREAM = 1'b1;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        node_t            data;
    } ram_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

endpackage

`default_nettype wire

>>> rtl/htsd_node_ram.sv
// node table: one write port, one registered read port, out-of-range reads give zero
`default_nettype none

module htsd_node_ram #(
    parameter int DEPTH = 512
) (
    input  logic              clk,
    input  htsd_pkg::ram_wr_t wr,
    input  htsd_pkg::ram_rd_t rd,
    output htsd_pkg::node_t   rdata
);
    import htsd_pkg::*;

    localparam int           AW    = $clog2(DEPTH);
    localparam logic [IDX_W:0] LIMIT = (IDX_W + 1)'(DEPTH);

    node_t mem [DEPTH];
    node_t q_reg;
    logic  hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && ({1'b0, wr.addr} < LIMIT))
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            q_reg   <= mem[rd.addr[AW-1:0]];
            hit_reg <= ({1'b0, rd.addr} < LIMIT);
        end
    end

    assign rdata = hit_reg ? q_reg : '0;

endmodule

`default_nettype wire

>>> rtl/huffman_tree_stream_decoder.sv
// huffman tree stream decoder: node loading, header handling and bit-serial tree walk
//
//  channel | signals                           | content
//  --------+-----------------------------------+-------------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser | tree node load or one stream byte
//          | s_tlast                           | s_tlast marks the final stream byte
//  out     | m_tvalid m_tready m_tdata m_tlast | decoded symbol, tlast on last of its byte
//  cfg     | cfg_valid cfg_ready cfg_data      | root node index
//
// load and header requests are handled as they are accepted; a data byte is walked bit by
// bit, through S_FETCH and S_DESCEND from the root and S_CHECK for each bit, then S_FLUSH,
// or straight to S_FLUSH when no bits are left, paced by the single read port of the node
// table that every bit of the walk depends on
// s_tready is low while a byte is being walked; a full output register stalls the walk
// reset (rst_n, asynchronous) clears control state; the node table is not cleared
`default_nettype none

module huffman_tree_stream_decoder #(
    parameter int NODE_COUNT = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // node_index[8:0] node_is_leaf[9] node_symbol[17:10] left_child[26:18]
    // right_child[35:27] data_byte[43:36], zero fill[47:44]
    input  logic [47:0] s_tdata,
    // cmd[0]
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // symbol[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);
    import htsd_pkg::*;

    localparam int DEPTH = (NODE_COUNT < TABLE_MAX) ? NODE_COUNT : TABLE_MAX;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DESCEND,
        S_CHECK,
        S_FLUSH
    } state_t;

    state_t           state_reg,      state_next;
    logic [IDX_W-1:0] root_reg,       root_next;
    logic [IDX_W-1:0] walk_reg,       walk_next;
    logic [IDX_W-1:0] nxt_reg,        nxt_next;
    logic             header_reg,     header_next;
    logic [CNT_W-1:0] pad_reg,        pad_next;
    logic [CNT_W-1:0] rem_reg,        rem_next;
    logic [7:0]       sh_reg,         sh_next;
    logic             fin_reg,        fin_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_sym_reg,   pend_sym_next;
    logic             out_valid_reg,  out_valid_next;
    logic [SYM_W-1:0] out_sym_reg,    out_sym_next;
    logic             out_last_reg,   out_last_next;

    ram_wr_t          wr;
    ram_rd_t          rd;
    node_t            rdata;

    logic             s_accept;
    logic             out_free;
    logic [7:0]       in_byte;
    logic [CNT_W-1:0] nbits;

    htsd_node_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_sym_reg;
    assign m_tlast   = out_last_reg;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign in_byte  = s_tdata[43:36];
    assign nbits    = s_tlast ? (BYTE_BITS - pad_reg) : BYTE_BITS;

    always_comb
    begin
        state_next      = state_reg;
        root_next       = cfg_valid ? cfg_data : root_reg;
        walk_next       = walk_reg;
        nxt_next        = nxt_reg;
        header_next     = header_reg;
        pad_next        = pad_reg;
        rem_next        = rem_reg;
        sh_next         = sh_reg;
        fin_next        = fin_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_last_next   = out_last_reg;
        wr              = '0;
        rd              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    if (s_tuser[0] == CMD_LOAD)
                    begin
                        wr.en         = 1'b1;
                        wr.addr       = s_tdata[8:0];
                        wr.data.leaf  = s_tdata[9];
                        wr.data.sym   = s_tdata[17:10];
                        wr.data.left  = s_tdata[26:18];
                        wr.data.right = s_tdata[35:27];
                    end
                    else if (header_reg)
                    begin
                        // pad count, saturated to a whole byte
                        pad_next    = (in_byte > 8'(BYTE_BITS)) ? BYTE_BITS : in_byte[3:0];
                        header_next = 1'b0;
                        walk_next   = root_reg;
                        if (s_tlast)
                        begin
                            header_next = 1'b1;
                            pad_next    = '0;
                        end
                    end
                    else
                    begin
                        sh_next    = in_byte;
                        fin_next   = s_tlast;
                        rem_next   = nbits;
                        state_next = (nbits == '0) ? S_FLUSH : S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                rd.en      = 1'b1;
                rd.addr    = walk_reg;
                state_next = S_DESCEND;
            end

            S_DESCEND:
            begin
                rd.en      = 1'b1;
                rd.addr    = sh_reg[7] ? rdata.right : rdata.left;
                nxt_next   = rd.addr;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (rdata.leaf)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_sym_next   = pend_sym_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = rdata.sym;
                        walk_next       = root_reg;
                        sh_next         = {sh_reg[6:0], 1'b0};
                        rem_next        = rem_reg - 1'b1;
                        state_next      = (rem_reg == 4'd1) ? S_FLUSH : S_FETCH;
                    end
                end
                else
                begin
                    walk_next = nxt_reg;
                    sh_next   = {sh_reg[6:0], 1'b0};
                    rem_next  = rem_reg - 1'b1;
                    if (rem_reg == 4'd1)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        // inner node already in hand: descend on the next bit straight away
                        rd.en    = 1'b1;
                        rd.addr  = sh_reg[6] ? rdata.right : rdata.left;
                        nxt_next = rd.addr;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_sym_next   = pend_sym_reg;
                        out_last_next  = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    if (fin_reg)
                    begin
                        header_next = 1'b1;
                        pad_next    = '0;
                        walk_next   = root_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            root_reg       <= '0;
            walk_reg       <= '0;
            header_reg     <= 1'b1;
            pad_reg        <= '0;
            rem_reg        <= '0;
            fin_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            walk_reg       <= walk_next;
            header_reg     <= header_next;
            pad_reg        <= pad_next;
            rem_reg        <= rem_next;
            fin_reg        <= fin_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nxt_reg      <= nxt_next;
        sh_reg       <= sh_next;
        pend_sym_reg <= pend_sym_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

    // no symbol may be held back once the block takes requests again
    a_pend_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_valid_reg)
        else $error("pending symbol left over at idle");

    // a node fetch is only issued while bits remain in the byte
    a_fetch_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH || state_reg == S_DESCEND || state_reg == S_CHECK)
        |-> (rem_reg != '0))
        else $error("tree walk running with no bits left");

    // between streams the pad count is cleared
    a_pad_clear: assert property (@(posedge clk) disable iff (!rst_n)
        header_reg |-> (pad_reg == '0))
        else $error("pad count set while waiting for a header");

    // pad count never exceeds one byte
    a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
        pad_reg <= BYTE_BITS)
        else $error("pad count above byte size");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the huffman tree stream decoder, with its own decode predictor
module tb_top;
    import htsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 32;
    localparam int RAND_ITEMS     = 380;
    localparam int DIR_ROWS       = 23;

    // one request on the input stream, split into its fields
    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] idx;
        logic             leaf;
        logic [SYM_W-1:0] sym;
        logic [IDX_W-1:0] lc;
        logic [IDX_W-1:0] rc;
        logic [7:0]       data;
        logic             fin;
    } req_t;

    typedef struct packed {
        logic             cfg_en;
        logic [IDX_W-1:0] cfg_root;
        req_t             req;
        logic             chk;
        logic [3:0]       cnt;
        logic [SYM_W-1:0] esym;
    } dir_row_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } sym_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // node_index[8:0] node_is_leaf[9] node_symbol[17:10] left_child[26:18]
    // right_child[35:27] data_byte[43:36], zero fill[47:44]
    logic [47:0] s_tdata;
    // cmd[0]
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    // symbol[7:0]
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    huffman_tree_stream_decoder #(
        .NODE_COUNT(TABLE_MAX)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // shadow of the decoder state
    node_t            node_mem   [0:TABLE_MAX-1];
    logic             node_known [0:TABLE_MAX-1];
    logic [IDX_W-1:0] root_sh;
    logic [IDX_W-1:0] walk_sh;
    logic             hdr_pend;
    logic [3:0]       pad_cnt;
    sym_res_t         sym_expect_q [$];

    dir_row_t dir_tab [0:DIR_ROWS-1];
    int       src_idle_pct;
    int       snk_stall_pct;
    int       items_sent;
    int       fail_cnt;
    int       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic dir_row_t load_row(input logic [IDX_W-1:0] idx, input logic leaf,
                                          input logic [SYM_W-1:0] sym,
                                          input logic [IDX_W-1:0] lc,
                                          input logic [IDX_W-1:0] rc);
        dir_row_t row;
        begin
            row = '0;
            row.req.cmd  = CMD_LOAD;
            row.req.idx  = idx;
            row.req.leaf = leaf;
            row.req.sym  = sym;
            row.req.lc   = lc;
            row.req.rc   = rc;
            return row;
        end
    endfunction

    function automatic dir_row_t byte_row(input logic cfg_en, input logic [IDX_W-1:0] root,
                                          input logic [7:0] data, input logic fin,
                                          input logic chk, input logic [3:0] cnt,
                                          input logic [SYM_W-1:0] esym);
        dir_row_t row;
        begin
            row = '0;
            row.cfg_en   = cfg_en;
            row.cfg_root = root;
            row.req.cmd  = CMD_STREAM;
            row.req.data = data;
            row.req.fin  = fin;
            row.chk      = chk;
            row.cnt      = cnt;
            row.esym     = esym;
            return row;
        end
    endfunction

    // updates the shadow for one accepted request; a data byte walks the shadow tree and queues the symbols it yields
    task automatic predict_symbols(input req_t r);
        node_t            cur;
        node_t            dst;
        logic [IDX_W-1:0] nxt;
        sym_res_t         res;
        int               nbits;
        int               emitted;
        begin
            if (r.cmd == CMD_LOAD)
            begin
                node_mem[r.idx]   = {r.leaf, r.sym, r.lc, r.rc};
                node_known[r.idx] = 1'b1;
            end
            else if (hdr_pend)
            begin
                pad_cnt  = (r.data > 8) ? BYTE_BITS : r.data[3:0];
                hdr_pend = 1'b0;
                walk_sh  = root_sh;
                // header that is also final: empty stream
                if (r.fin)
                begin
                    hdr_pend = 1'b1;
                    pad_cnt  = '0;
                end
            end
            else
            begin
                nbits   = r.fin ? 8 - pad_cnt : 8;
                emitted = 0;
                for (int i = 0; i < nbits; i++)
                begin
                    cur = node_mem[walk_sh];
                    nxt = r.data[7-i] ? cur.right : cur.left;
                    dst = node_mem[nxt];
                    if (dst.leaf)
                    begin
                        res.sym  = dst.sym;
                        res.last = 1'b0;
                        sym_expect_q.insert(sym_expect_q.size(), res);
                        emitted++;
                        walk_sh = root_sh;
                    end
                    else
                    begin
                        walk_sh = nxt;
                    end
                end
                if (emitted > 0)
                begin
                    res      = sym_expect_q[sym_expect_q.size() - 1];
                    res.last = 1'b1;
                    sym_expect_q[sym_expect_q.size() - 1] = res;
                end
                // a partial code at the end of the stream is dropped
                if (r.fin)
                begin
                    hdr_pend = 1'b1;
                    pad_cnt  = '0;
                    walk_sh  = root_sh;
                end
            end
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_in(input req_t r, input logic chk, input logic [3:0] cnt,
                            input logic [SYM_W-1:0] esym);
        int       base;
        sym_res_t res;
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0, r.data, r.rc, r.lc, r.sym, r.leaf, r.idx};
            s_tuser  <= r.cmd;
            s_tlast  <= r.fin;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            base = sym_expect_q.size();
            predict_symbols(r);
            // rows with a hand-written answer replace what the predictor queued
            if (chk)
            begin
                while (sym_expect_q.size() > base)
                    sym_expect_q.delete(sym_expect_q.size() - 1);
                for (int k = 0; k < cnt; k++)
                begin
                    res.sym  = esym;
                    res.last = (k == cnt - 1);
                    sym_expect_q.insert(sym_expect_q.size(), res);
                end
            end
            items_sent++;
            @(negedge clk);
        end
    endtask

    task automatic write_root(input logic [IDX_W-1:0] v);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= v;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            root_sh = v;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // let the decoder drain: all symbols back, then the tail of the last byte walk
    task automatic settle;
        begin
            s_tvalid <= 1'b0;
            while (sym_expect_q.size() != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    function automatic logic [IDX_W-1:0] pick_known();
        logic [IDX_W-1:0] v;
        begin
            v = IDX_W'($urandom_range(TABLE_MAX - 1));
            while (!node_known[v])
                v = IDX_W'($urandom_range(TABLE_MAX - 1));
            return v;
        end
    endfunction

    // loads a random full binary code tree at scattered indices
    task automatic grow_tree(output logic [IDX_W-1:0] top);
        logic [IDX_W-1:0] slot  [0:15];
        logic             inner [0:15];
        int               lkid  [0:15];
        int               rkid  [0:15];
        int               n_nodes;
        int               n_leaves;
        int               want;
        int               k;
        int               j;
        logic             clash;
        req_t             r;
        begin
            want     = $urandom_range(2, 8);
            n_nodes  = 1;
            n_leaves = 1;
            inner[0] = 1'b0;
            slot[0]  = IDX_W'($urandom_range(TABLE_MAX - 1));
            while (n_leaves < want)
            begin
                k = $urandom_range(n_nodes - 1);
                if (!inner[k])
                begin
                    inner[k] = 1'b1;
                    lkid[k]  = n_nodes;
                    rkid[k]  = n_nodes + 1;
                    for (int c = 0; c < 2; c++)
                    begin
                        do
                        begin
                            clash = 1'b0;
                            slot[n_nodes] = IDX_W'($urandom_range(TABLE_MAX - 1));
                            for (j = 0; j < n_nodes; j++)
                                if (slot[j] == slot[n_nodes])
                                    clash = 1'b1;
                        end
                        while (clash);
                        inner[n_nodes] = 1'b0;
                        n_nodes++;
                    end
                    n_leaves++;
                end
            end
            for (j = 0; j < n_nodes; j++)
            begin
                r.cmd  = CMD_LOAD;
                r.idx  = slot[j];
                r.leaf = !inner[j];
                r.sym  = SYM_W'($urandom_range(255));
                if (inner[j])
                begin
                    r.lc = slot[lkid[j]];
                    r.rc = slot[rkid[j]];
                end
                else
                begin
                    // leaf children stay inside the tree
                    r.lc = slot[$urandom_range(n_nodes - 1)];
                    r.rc = slot[$urandom_range(n_nodes - 1)];
                end
                r.data = 8'($urandom_range(255));
                r.fin  = 1'($urandom_range(1));
                drive_in(r, 1'b0, 4'd0, 8'h00);
            end
            top = slot[0];
        end
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sym_expect_q.size() == 0)
            begin
                $display("%0t unexpected symbol: expected none, got %h last %b",
                         $time, m_tdata, m_tlast);
                fail_cnt++;
            end
            else
            begin
                if (m_tdata !== sym_expect_q[0].sym)
                begin
                    $display("%0t symbol mismatch: expected %h, got %h",
                             $time, sym_expect_q[0].sym, m_tdata);
                    fail_cnt++;
                end
                if (m_tlast !== sym_expect_q[0].last)
                begin
                    $display("%0t last_of_byte mismatch: expected %b, got %b",
                             $time, sym_expect_q[0].last, m_tlast);
                    fail_cnt++;
                end
                void'(sym_expect_q.pop_front());
            end
        end
    end

    // cycles with no request moving on any channel
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int               ph;
        int               roll;
        int               burst;
        int               phase_goal;
        req_t             rq;
        logic [IDX_W-1:0] new_top;

        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        items_sent    = 0;
        fail_cnt      = 0;
        for (int n = 0; n < TABLE_MAX; n++)
        begin
            node_mem[n]   = '0;
            node_known[n] = 1'b0;
        end
        root_sh  = '0;
        walk_sh  = '0;
        hdr_pend = 1'b1;
        pad_cnt  = '0;

        // root 0 splits into a NUL leaf on bit 0 and an 0xff leaf on bit 1
        dir_tab[0]  = load_row(9'd1, 1'b1, 8'h00, 9'd0, 9'd0);
        dir_tab[1]  = load_row(9'd2, 1'b1, 8'hFF, 9'd511, 9'd511);
        dir_tab[2]  = load_row(9'd0, 1'b0, 8'h00, 9'd1, 9'd2);
        dir_tab[3]  = load_row(9'd511, 1'b0, 8'hAA, 9'd1, 9'd2);
        dir_tab[4]  = load_row(9'd3, 1'b1, 8'h5A, 9'd1, 9'd2);
        // no padding
        dir_tab[5]  = byte_row(1'b0, 9'd0, 8'h00, 1'b0, 1'b1, 4'd0, 8'h00);
        dir_tab[6]  = byte_row(1'b0, 9'd0, 8'h00, 1'b0, 1'b1, 4'd8, 8'h00);
        dir_tab[7]  = byte_row(1'b0, 9'd0, 8'hFF, 1'b0, 1'b1, 4'd8, 8'hFF);
        dir_tab[8]  = byte_row(1'b0, 9'd0, 8'hA5, 1'b1, 1'b0, 4'd0, 8'h00);
        // whole final byte padded away
        dir_tab[9]  = byte_row(1'b0, 9'd0, 8'h08, 1'b0, 1'b1, 4'd0, 8'h00);
        dir_tab[10] = byte_row(1'b0, 9'd0, 8'hFF, 1'b1, 1'b1, 4'd0, 8'h00);
        // pad count saturates at eight
        dir_tab[11] = byte_row(1'b0, 9'd0, 8'hFF, 1'b0, 1'b1, 4'd0, 8'h00);
        dir_tab[12] = byte_row(1'b0, 9'd0, 8'h0F, 1'b1, 1'b1, 4'd0, 8'h00);
        // empty stream
        dir_tab[13] = byte_row(1'b0, 9'd0, 8'h03, 1'b1, 1'b1, 4'd0, 8'h00);
        dir_tab[14] = byte_row(1'b0, 9'd0, 8'h04, 1'b0, 1'b1, 4'd0, 8'h00);
        dir_tab[15] = byte_row(1'b0, 9'd0, 8'hF0, 1'b0, 1'b0, 4'd0, 8'h00);
        dir_tab[16] = byte_row(1'b0, 9'd0, 8'hC3, 1'b1, 1'b0, 4'd0, 8'h00);
        // root moved to a leaf node in the middle of a stream
        dir_tab[17] = byte_row(1'b0, 9'd0, 8'h01, 1'b0, 1'b1, 4'd0, 8'h00);
        dir_tab[18] = byte_row(1'b1, 9'd3, 8'h80, 1'b0, 1'b0, 4'd0, 8'h00);
        dir_tab[19] = byte_row(1'b0, 9'd0, 8'h55, 1'b1, 1'b0, 4'd0, 8'h00);
        dir_tab[20] = byte_row(1'b1, 9'd511, 8'h02, 1'b0, 1'b1, 4'd0, 8'h00);
        dir_tab[21] = byte_row(1'b0, 9'd0, 8'h3C, 1'b1, 1'b0, 4'd0, 8'h00);
        dir_tab[22] = byte_row(1'b1, 9'd0, 8'h00, 1'b1, 1'b1, 4'd0, 8'h00);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].cfg_en)
            begin
                settle();
                write_root(dir_tab[i].cfg_root);
            end
            drive_in(dir_tab[i].req, dir_tab[i].chk, dir_tab[i].cnt, dir_tab[i].esym);
        end

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
                default: begin src_idle_pct = 25; snk_stall_pct = 25; end
            endcase
            phase_goal = items_sent + RAND_ITEMS / 4;
            while (items_sent < phase_goal)
            begin
                if ($urandom_range(99) < 40)
                    grow_tree(new_top);
                else
                    new_top = pick_known();
                settle();
                roll = $urandom_range(99);
                if (roll < 15)
                    write_root(9'd0);
                else if (roll < 30)
                    write_root(9'd511);
                else
                    write_root(new_top);
                burst = $urandom_range(3, 14);
                repeat (burst)
                begin
                    rq.idx  = IDX_W'($urandom_range(TABLE_MAX - 1));
                    rq.leaf = 1'($urandom_range(1));
                    rq.sym  = SYM_W'($urandom_range(255));
                    rq.lc   = IDX_W'($urandom_range(TABLE_MAX - 1));
                    rq.rc   = IDX_W'($urandom_range(TABLE_MAX - 1));
                    if ($urandom_range(9) == 0)
                    begin
                        // stray node write; children stay on written entries
                        rq.cmd  = CMD_LOAD;
                        rq.lc   = pick_known();
                        rq.rc   = pick_known();
                        rq.data = 8'($urandom_range(255));
                        rq.fin  = 1'($urandom_range(1));
                    end
                    else if (hdr_pend)
                    begin
                        rq.cmd  = CMD_STREAM;
                        rq.data = 8'(($urandom_range(99) < 85) ? $urandom_range(8)
                                                               : $urandom_range(255));
                        rq.fin  = ($urandom_range(99) < 8);
                    end
                    else
                    begin
                        rq.cmd  = CMD_STREAM;
                        rq.data = 8'($urandom_range(255));
                        rq.fin  = ($urandom_range(4) == 0);
                    end
                    drive_in(rq, 1'b0, 4'd0, 8'h00);
                end
            end
        end

        settle();
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> huffman_tree_stream_decoder.f
rtl/htsd_pkg.sv
rtl/htsd_node_ram.sv
rtl/huffman_tree_stream_decoder.sv
bench/tb_top.sv
